// ===== src/ssr_pkg.sv =====
// Shared types and constants of the stepper speed ramp generator.
package ssr_pkg;

  // Action codes carried in tuser of the input stream.
  typedef enum logic [1:0] {
    ACT_STEP    = 2'd0,
    ACT_ACCEL   = 2'd1,
    ACT_DECEL   = 2'd2,
    ACT_INSTANT = 2'd3
  } action_t;

  localparam int ACCEL_WIDTH     = 15;
  localparam int DIST_WIDTH      = 31;
  localparam int POS_WIDTH       = 32;
  localparam int TIME_WIDTH      = 32;
  localparam int OUT_SPEED_WIDTH = 23;
  localparam int OUT_DATA_WIDTH  = 32;

  // An acceleration of this value means the target is set at once.
  localparam logic [ACCEL_WIDTH-1:0] ACCEL_AT_ONCE = '0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mul;
    logic is_decel;
    logic div_sat;
    logic div_last;
  } status_t;

endpackage

// ===== src/stepper_speed_ramp.sv =====
// Stepper speed ramp generator: top level joining controller and datapath.
// Each input transfer is a command (set target instantly, start a time-based
// acceleration, start a distance-based deceleration) or a control step that
// carries the current time and position; every transfer yields exactly one
// result transfer with the commanded speed and the ramp, driver and write
// flags. Items are handled one at a time. A command, a step outside a ramp
// and a decelerating step with a zero ramp length pass only the decide and
// commit states; an accelerating step also passes the multiplier, any other
// decelerating step the multiplier, the divider set-up and, unless its drop
// exceeds every speed, the restoring divider with one quotient bit per cycle.
// A new item is accepted while the previous result still waits in the output
// register; its own result then waits until that transfer completes.
module stepper_speed_ramp #(
  parameter int SPEED_WIDTH = 23
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // target, acceleration, ramp_distance, position, now_ms, zero padding
  input  logic [((SPEED_WIDTH+117)/8)*8-1:0]  s_tdata,
  // action
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // speed, ramp_active, driver_on, speed_written, zero padding
  output logic [ssr_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);
  import ssr_pkg::*;

  localparam int SW        = SPEED_WIDTH;
  localparam int ACC_LSB   = SW;
  localparam int DIST_LSB  = ACC_LSB + ACCEL_WIDTH;
  localparam int POS_LSB   = DIST_LSB + DIST_WIDTH;
  localparam int TIME_LSB  = POS_LSB + POS_WIDTH;

  cmd_t    cmd;
  status_t status;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ssr_datapath #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (s_tuser),
    .target        (s_tdata[SW-1:0]),
    .acceleration  (s_tdata[DIST_LSB-1:ACC_LSB]),
    .ramp_distance (s_tdata[POS_LSB-1:DIST_LSB]),
    .position      (s_tdata[TIME_LSB-1:POS_LSB]),
    .now_ms        (s_tdata[TIME_LSB+TIME_WIDTH-1:TIME_LSB]),
    .result        (m_tdata)
  );

endmodule

// ===== src/ssr_ctrl.sv =====
// Controller state machine of the stepper speed ramp generator.
module ssr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  ssr_pkg::status_t status,
  output ssr_pkg::cmd_t    cmd
);
  import ssr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECIDE  = 6'b000010,
    S_MUL     = 6'b000100,
    S_DIVINIT = 6'b001000,
    S_DIV     = 6'b010000,
    S_COMMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  // The result register can be reloaded in the cycle its transfer completes.
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load     = s_tvalid && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = status.need_mul ? S_MUL : S_COMMIT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.is_decel ? S_DIVINIT : S_COMMIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = status.div_sat ? S_COMMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/ssr_datapath.sv =====
// Datapath of the stepper speed ramp generator: ramp state, multiplier and serial divider.
module ssr_datapath #(
  parameter int SPEED_WIDTH = 23
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  ssr_pkg::cmd_t                           cmd,
  output ssr_pkg::status_t                        status,
  input  logic [1:0]                              action,
  input  logic [SPEED_WIDTH-1:0]                  target,
  input  logic [ssr_pkg::ACCEL_WIDTH-1:0]         acceleration,
  input  logic [ssr_pkg::DIST_WIDTH-1:0]          ramp_distance,
  input  logic signed [ssr_pkg::POS_WIDTH-1:0]    position,
  input  logic [ssr_pkg::TIME_WIDTH-1:0]          now_ms,
  output logic [ssr_pkg::OUT_DATA_WIDTH-1:0]      result
);
  import ssr_pkg::*;

  localparam int SW  = SPEED_WIDTH;
  localparam int MB  = (SW > ACCEL_WIDTH) ? SW : ACCEL_WIDTH;
  localparam int PW  = TIME_WIDTH + MB;
  localparam int PHW = PW - SW;
  localparam int CW  = $clog2(SW);

  // Captured item
  action_t                act;
  logic [SW-1:0]          tgt;
  logic [ACCEL_WIDTH-1:0] acc;
  logic [DIST_WIDTH-1:0]  ramp_dist;
  logic [POS_WIDTH-1:0]   pos;
  logic [TIME_WIDTH-1:0]  now;

  // Ramp state
  logic [SW-1:0]          speed_now;
  logic [SW-1:0]          speed_goal;
  logic [SW-1:0]          start_speed;
  logic [ACCEL_WIDTH-1:0] ramp_rate;
  logic [TIME_WIDTH-1:0]  start_time;
  logic [POS_WIDTH-1:0]   start_pos;
  logic [DIST_WIDTH-1:0]  ramp_len;
  logic                   ramping;
  logic                   drv_en;

  logic [SW-1:0]          speed_now_next;
  logic [SW-1:0]          speed_goal_next;
  logic [SW-1:0]          start_speed_next;
  logic [ACCEL_WIDTH-1:0] ramp_rate_next;
  logic [TIME_WIDTH-1:0]  start_time_next;
  logic [POS_WIDTH-1:0]   start_pos_next;
  logic [DIST_WIDTH-1:0]  ramp_len_next;
  logic                   ramping_next;
  logic                   drv_en_next;
  logic                   written;

  // Arithmetic
  logic                   accel_br;
  logic [TIME_WIDTH-1:0]  dt;
  logic [POS_WIDTH:0]     dpos;
  logic [POS_WIDTH:0]     dabs;
  logic [SW-1:0]          span;
  logic [TIME_WIDTH-1:0]  op_a;
  logic [MB-1:0]          op_b;
  logic [PW-1:0]          prod;
  logic [PHW-1:0]         phi;
  logic                   sat_now;
  logic                   sat;
  logic [DIST_WIDTH-1:0]  rem;
  logic [DIST_WIDTH:0]    rem2;
  logic [DIST_WIDTH:0]    rem_sub;
  logic                   rem_ge;
  logic [SW-1:0]          dividend;
  logic [SW-1:0]          quot;
  logic [CW-1:0]          cnt;
  logic [PW:0]            acc_sum;
  logic [SW-1:0]          dec_speed;
  logic [SW+OUT_SPEED_WIDTH-1:0] speed_ext;

  assign accel_br = (speed_now < speed_goal);
  assign dt       = now - start_time;
  assign dpos     = {pos[POS_WIDTH-1], pos} - {start_pos[POS_WIDTH-1], start_pos};
  assign dabs     = dpos[POS_WIDTH] ? ((POS_WIDTH+1)'(0) - dpos) : dpos;
  assign span     = (speed_goal > start_speed) ? (speed_goal - start_speed)
                                               : (start_speed - speed_goal);

  // One multiplier serves both ramps: elapsed time by rate, or distance by speed span.
  assign op_a = accel_br ? dt : dabs[POS_WIDTH-1:0];
  assign op_b = accel_br ? MB'(ramp_rate) : MB'(span);

  // A high part of the product not below the ramp length means the drop
  // exceeds every representable speed, so the division is skipped.
  assign phi     = prod[PW-1:SW];
  assign sat_now = (phi >= PHW'(ramp_len));

  assign rem2    = {rem, dividend[SW-1]};
  assign rem_sub = rem2 - {1'b0, ramp_len};
  assign rem_ge  = (rem2 >= {1'b0, ramp_len});

  assign status.need_mul = (act == ACT_STEP) && ramping && (accel_br || (ramp_len != '0));
  assign status.is_decel = !accel_br;
  assign status.div_sat  = sat_now;
  assign status.div_last = (cnt == CW'(SW - 1));

  assign acc_sum   = (PW+1)'(start_speed) + (PW+1)'(prod);
  assign dec_speed = (sat || (quot >= start_speed)) ? '0 : (start_speed - quot);

  always_comb begin
    speed_now_next   = speed_now;
    speed_goal_next  = speed_goal;
    start_speed_next = start_speed;
    ramp_rate_next   = ramp_rate;
    start_time_next  = start_time;
    start_pos_next   = start_pos;
    ramp_len_next    = ramp_len;
    ramping_next     = ramping;
    written          = 1'b0;
    case (act)
      ACT_STEP: begin
        if (ramping) begin
          written = 1'b1;
          if (accel_br) begin
            if (acc_sum > (PW+1)'(speed_goal)) begin
              speed_now_next = speed_goal;
              ramping_next   = 1'b0;
            end else begin
              speed_now_next = acc_sum[SW-1:0];
            end
          end else if (ramp_len == '0) begin
            speed_now_next = speed_goal;
            ramping_next   = 1'b0;
          end else if (dec_speed < speed_goal) begin
            speed_now_next = speed_goal;
            ramping_next   = 1'b0;
          end else begin
            speed_now_next = dec_speed;
          end
        end
      end
      ACT_ACCEL: begin
        speed_goal_next = tgt;
        if ((acc == ACCEL_AT_ONCE) || (tgt <= speed_goal)) begin
          speed_now_next = tgt;
          written        = 1'b1;
        end else begin
          start_speed_next = speed_now;
          ramp_rate_next   = acc;
          start_time_next  = now;
          ramping_next     = 1'b1;
        end
      end
      ACT_DECEL: begin
        if (tgt != speed_goal) begin
          speed_goal_next  = tgt;
          start_speed_next = speed_now;
          ramp_len_next    = ramp_dist;
          start_pos_next   = pos;
          ramping_next     = 1'b1;
        end
      end
      ACT_INSTANT: begin
        speed_now_next  = tgt;
        speed_goal_next = tgt;
        written         = 1'b1;
      end
      default: begin
        written = 1'b0;
      end
    endcase
    drv_en_next = written ? (speed_now_next != '0) : drv_en;
  end

  assign speed_ext = {{OUT_SPEED_WIDTH{1'b0}}, speed_now_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act       <= action_t'(action);
      tgt       <= target;
      acc       <= acceleration;
      ramp_dist <= ramp_distance;
      pos       <= position;
      now       <= now_ms;
    end
    if (cmd.mul) begin
      prod <= PW'(op_a) * PW'(op_b);
    end
    if (cmd.div_init) begin
      sat      <= sat_now;
      rem      <= phi[DIST_WIDTH-1:0];
      dividend <= prod[SW-1:0];
      quot     <= '0;
      cnt      <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_ge ? rem_sub[DIST_WIDTH-1:0] : rem2[DIST_WIDTH-1:0];
      dividend <= {dividend[SW-2:0], 1'b0};
      quot     <= {quot[SW-2:0], rem_ge};
      cnt      <= cnt + 1'b1;
    end
    if (cmd.commit) begin
      result <= {{(OUT_DATA_WIDTH-OUT_SPEED_WIDTH-3){1'b0}}, written, drv_en_next,
                 ramping_next, speed_ext[OUT_SPEED_WIDTH-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now   <= '0;
      speed_goal  <= '0;
      start_speed <= '0;
      ramp_rate   <= '0;
      start_time  <= '0;
      start_pos   <= '0;
      ramp_len    <= '0;
      ramping     <= 1'b0;
      drv_en      <= 1'b0;
    end else if (cmd.commit) begin
      speed_now   <= speed_now_next;
      speed_goal  <= speed_goal_next;
      start_speed <= start_speed_next;
      ramp_rate   <= ramp_rate_next;
      start_time  <= start_time_next;
      start_pos   <= start_pos_next;
      ramp_len    <= ramp_len_next;
      ramping     <= ramping_next;
      drv_en      <= drv_en_next;
    end
  end

endmodule

// ===== src/ssr_checker.sv =====
// Port-level checks of the stepper speed ramp generator and their binding.
module ssr_checker #(
  parameter int SPEED_WIDTH = 23
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [((SPEED_WIDTH+117)/8)*8-1:0]  s_tdata,
  input logic [1:0]                          s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [ssr_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);
  import ssr_pkg::*;

  // A stalled result transfer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Only one item is in work: an accepted transfer closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after a transfer");

  // A new result only appears after an item has been in work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without an item in work");

  // The driver is enabled exactly when the commanded speed is nonzero.
  a_driver_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (SPEED_WIDTH <= OUT_SPEED_WIDTH)
      |-> m_tdata[OUT_SPEED_WIDTH+1] == (m_tdata[OUT_SPEED_WIDTH-1:0] != '0))
    else $error("driver enable does not follow speed");

endmodule

bind stepper_speed_ramp ssr_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_ssr_checker (.*);
